@@ rtl/core/vtbb_pkg.sv @@
// ----------------------------------------------------------------------------
// vtbb_pkg
// Shared widths, register codes, types and helpers of the thresholded volume
// bounding box core.
// ----------------------------------------------------------------------------
package vtbb_pkg;

  localparam int MAX_DIM    = 1024;
  localparam int VOXEL_BITS = 16;

  // Fixed field widths of the interface
  localparam int VAL_W  = 16;
  localparam int SIZE_W = 11;
  localparam int OUT_W  = 10;

  localparam int POS_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CMP_W = (POS_W + 1 > SIZE_W) ? POS_W + 1 : SIZE_W;

  localparam logic [VAL_W-1:0] VOXEL_MASK = VAL_W'((64'd1 << VOXEL_BITS) - 64'd1);

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_X    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_Y    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_Z    = 2'd3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

  typedef struct packed {
    logic [VAL_W-1:0]  threshold;
    logic [SIZE_W-1:0] size_x;
    logic [SIZE_W-1:0] size_y;
    logic [SIZE_W-1:0] size_z;
  } vtbb_cfg_t;

  typedef struct packed {
    logic [OUT_W-1:0] low_x;
    logic [OUT_W-1:0] high_x;
    logic [OUT_W-1:0] low_y;
    logic [OUT_W-1:0] high_y;
    logic [OUT_W-1:0] low_z;
    logic [OUT_W-1:0] high_z;
    logic             any_found;
    logic             crop_needed;
  } vtbb_result_t;

  typedef struct packed {
    logic         valid;
    vtbb_result_t result;
  } vtbb_push_t;

  // Zero counts as one, anything above MAX_DIM counts as MAX_DIM
  function automatic logic [CMP_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [CMP_W-1:0] se;
    se = CMP_W'(s);
    if (s == '0) begin
      return CMP_W'(1);
    end
    if (se > CMP_W'(MAX_DIM)) begin
      return CMP_W'(MAX_DIM);
    end
    return se;
  endfunction

endpackage

@@ rtl/core/vtbb_if.sv @@
// ----------------------------------------------------------------------------
// vtbb_in_if / vtbb_out_if
// Valid/ready stream channels for voxel input and bounding box results.
// ----------------------------------------------------------------------------
interface vtbb_in_if import vtbb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] voxel_value;

  modport source (output valid, output voxel_value, input ready);
  modport sink   (input valid, input voxel_value, output ready);
endinterface

interface vtbb_out_if import vtbb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] low_x;
  logic [OUT_W-1:0] high_x;
  logic [OUT_W-1:0] low_y;
  logic [OUT_W-1:0] high_y;
  logic [OUT_W-1:0] low_z;
  logic [OUT_W-1:0] high_z;
  logic             any_found;
  logic             crop_needed;

  modport source (output valid, output low_x, output high_x, output low_y,
                  output high_y, output low_z, output high_z, output any_found,
                  output crop_needed, input ready);
  modport sink   (input valid, input low_x, input high_x, input low_y,
                  input high_y, input low_z, input high_z, input any_found,
                  input crop_needed, output ready);
endinterface

@@ rtl/core/vtbb_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// vtbb_cfg_regs
// APB register file: threshold and the three volume extents.
// ----------------------------------------------------------------------------
module vtbb_cfg_regs import vtbb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output vtbb_cfg_t             cfg
);

  vtbb_cfg_t              cfg_r;
  vtbb_cfg_t              cfg_nxt;
  logic                   wr_en;
  logic [REG_IDX_W-1:0]   reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_THRESHOLD: cfg_nxt.threshold = pwdata[VAL_W-1:0];
        REG_SIZE_X:    cfg_nxt.size_x    = pwdata[SIZE_W-1:0];
        REG_SIZE_Y:    cfg_nxt.size_y    = pwdata[SIZE_W-1:0];
        REG_SIZE_Z:    cfg_nxt.size_z    = pwdata[SIZE_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold <= '0;
      cfg_r.size_x    <= SIZE_RESET;
      cfg_r.size_y    <= SIZE_RESET;
      cfg_r.size_z    <= SIZE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_THRESHOLD: prdata = CFG_DATA_W'(cfg_r.threshold);
      REG_SIZE_X:    prdata = CFG_DATA_W'(cfg_r.size_x);
      REG_SIZE_Y:    prdata = CFG_DATA_W'(cfg_r.size_y);
      REG_SIZE_Z:    prdata = CFG_DATA_W'(cfg_r.size_z);
      default:       prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/core/vtbb_scan.sv @@
// ----------------------------------------------------------------------------
// vtbb_scan
// Input register, position counters and box tracker. Produces one result
// when the last voxel of a volume goes through.
// ----------------------------------------------------------------------------
module vtbb_scan import vtbb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  vtbb_cfg_t        cfg,
  input  logic             in_valid,
  input  logic [VAL_W-1:0] in_voxel,
  output logic             in_ready,
  input  logic             res_ready,
  output vtbb_push_t       push
);

  logic             s1_valid_r, s1_valid_nxt;
  logic [VAL_W-1:0] s1_voxel_r;

  logic [POS_W-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic [POS_W-1:0] min_x_r, min_y_r, min_z_r;
  logic [POS_W-1:0] max_x_r, max_y_r, max_z_r;
  logic             seen_r;

  logic [POS_W-1:0] pos_x_nxt, pos_y_nxt, pos_z_nxt;
  logic [POS_W-1:0] min_x_nxt, min_y_nxt, min_z_nxt;
  logic [POS_W-1:0] max_x_nxt, max_y_nxt, max_z_nxt;
  logic             seen_nxt;

  logic [CMP_W-1:0] sx, sy, sz;
  logic [CMP_W-1:0] inc_x, inc_y, inc_z;
  logic             wrap_x, wrap_y, wrap_z, last;
  logic             hit, go, in_xfer;

  logic [POS_W-1:0] mn_x, mn_y, mn_z, mx_x, mx_y, mx_z;
  logic             seen_upd;
  logic [POS_W-1:0] lx, hx, ly, hy, lz, hz;
  logic [CMP_W-1:0] ext_x, ext_y, ext_z;

  assign sx = eff_size(cfg.size_x);
  assign sy = eff_size(cfg.size_y);
  assign sz = eff_size(cfg.size_z);

  assign inc_x  = CMP_W'(pos_x_r) + CMP_W'(1);
  assign inc_y  = CMP_W'(pos_y_r) + CMP_W'(1);
  assign inc_z  = CMP_W'(pos_z_r) + CMP_W'(1);
  assign wrap_z = inc_z >= sz;
  assign wrap_y = inc_y >= sy;
  assign wrap_x = inc_x >= sx;
  assign last   = wrap_z & wrap_y & wrap_x;

  // A final voxel may only go when the result register can take its box
  assign go       = s1_valid_r & (~last | res_ready);
  assign in_ready = ~s1_valid_r | go;
  assign in_xfer  = in_valid & in_ready;

  assign hit = (s1_voxel_r & VOXEL_MASK) > cfg.threshold;

  always_comb begin
    mn_x = (hit && pos_x_r < min_x_r) ? pos_x_r : min_x_r;
    mn_y = (hit && pos_y_r < min_y_r) ? pos_y_r : min_y_r;
    mn_z = (hit && pos_z_r < min_z_r) ? pos_z_r : min_z_r;
    mx_x = (hit && pos_x_r > max_x_r) ? pos_x_r : max_x_r;
    mx_y = (hit && pos_y_r > max_y_r) ? pos_y_r : max_y_r;
    mx_z = (hit && pos_z_r > max_z_r) ? pos_z_r : max_z_r;
    seen_upd = seen_r | hit;
  end

  // Empty volume reports the single voxel at the origin
  always_comb begin
    lx = seen_upd ? mn_x : '0;
    hx = seen_upd ? mx_x : '0;
    ly = seen_upd ? mn_y : '0;
    hy = seen_upd ? mx_y : '0;
    lz = seen_upd ? mn_z : '0;
    hz = seen_upd ? mx_z : '0;
    ext_x = CMP_W'(hx) - CMP_W'(lx) + CMP_W'(1);
    ext_y = CMP_W'(hy) - CMP_W'(ly) + CMP_W'(1);
    ext_z = CMP_W'(hz) - CMP_W'(lz) + CMP_W'(1);
  end

  always_comb begin
    push.valid              = go & last;
    push.result.low_x       = OUT_W'(lx);
    push.result.high_x      = OUT_W'(hx);
    push.result.low_y       = OUT_W'(ly);
    push.result.high_y      = OUT_W'(hy);
    push.result.low_z       = OUT_W'(lz);
    push.result.high_z      = OUT_W'(hz);
    push.result.any_found   = seen_upd;
    push.result.crop_needed = (ext_x != sx) | (ext_y != sy) | (ext_z != sz);
  end

  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    pos_z_nxt = pos_z_r;
    min_x_nxt = min_x_r;
    min_y_nxt = min_y_r;
    min_z_nxt = min_z_r;
    max_x_nxt = max_x_r;
    max_y_nxt = max_y_r;
    max_z_nxt = max_z_r;
    seen_nxt  = seen_r;
    if (go) begin
      if (last) begin
        // Volume done: start fresh
        pos_x_nxt = '0;
        pos_y_nxt = '0;
        pos_z_nxt = '0;
        min_x_nxt = '1;
        min_y_nxt = '1;
        min_z_nxt = '1;
        max_x_nxt = '0;
        max_y_nxt = '0;
        max_z_nxt = '0;
        seen_nxt  = 1'b0;
      end else begin
        min_x_nxt = mn_x;
        min_y_nxt = mn_y;
        min_z_nxt = mn_z;
        max_x_nxt = mx_x;
        max_y_nxt = mx_y;
        max_z_nxt = mx_z;
        seen_nxt  = seen_upd;
        pos_z_nxt = wrap_z ? '0 : POS_W'(inc_z);
        if (wrap_z) begin
          pos_y_nxt = wrap_y ? '0 : POS_W'(inc_y);
          if (wrap_y) begin
            pos_x_nxt = POS_W'(inc_x);
          end
        end
      end
    end
  end

  assign s1_valid_nxt = in_xfer | (s1_valid_r & ~go);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      pos_x_r    <= '0;
      pos_y_r    <= '0;
      pos_z_r    <= '0;
      min_x_r    <= '1;
      min_y_r    <= '1;
      min_z_r    <= '1;
      max_x_r    <= '0;
      max_y_r    <= '0;
      max_z_r    <= '0;
      seen_r     <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      pos_x_r    <= pos_x_nxt;
      pos_y_r    <= pos_y_nxt;
      pos_z_r    <= pos_z_nxt;
      min_x_r    <= min_x_nxt;
      min_y_r    <= min_y_nxt;
      min_z_r    <= min_z_nxt;
      max_x_r    <= max_x_nxt;
      max_y_r    <= max_y_nxt;
      max_z_r    <= max_z_nxt;
      seen_r     <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_voxel_r <= in_voxel;
    end
  end

  // After a result the tracker is back at the origin with nothing seen
  a_clear_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |=> (pos_x_r == '0) && (pos_y_r == '0) && (pos_z_r == '0) && !seen_r)
    else $error("tracker not cleared after result");

  // A seen box is never inverted
  a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |-> (min_x_r <= max_x_r) && (min_y_r <= max_y_r) && (min_z_r <= max_z_r))
    else $error("box bounds inverted");

  // A held voxel keeps its value while the final step waits for room
  a_hold_voxel: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !go |=> s1_valid_r && $stable(s1_voxel_r))
    else $error("held voxel lost");

  // Box state only moves when a voxel goes through
  a_no_spurious_update: assert property (@(posedge clk) disable iff (!rst_n)
    !go |=> $stable(seen_r) && $stable(pos_z_r))
    else $error("tracker changed without a voxel");

endmodule

@@ rtl/core/vtbb_out_reg.sv @@
// ----------------------------------------------------------------------------
// vtbb_out_reg
// Result register driving the output channel.
// ----------------------------------------------------------------------------
module vtbb_out_reg import vtbb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  vtbb_push_t   push,
  output logic         res_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output vtbb_result_t out_data
);

  logic         out_valid_r, out_valid_nxt;
  vtbb_result_t out_data_r;

  assign res_ready = ~out_valid_r | out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (push.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      out_data_r <= push.result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Never overwrite a result that has not been transferred
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> (!out_valid_r || out_ready))
    else $error("result overwritten before transfer");

endmodule

@@ rtl/core/volume_threshold_bounding_box_core.sv @@
// ----------------------------------------------------------------------------
// volume_threshold_bounding_box_core
// Tight bounding box of the voxels above a threshold in a streamed volume.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one voxel per transfer, z fastest, then y, then x. The
//   core counts the position itself; the volume ends after
//   size_x * size_y * size_z voxels.
//   out_chan carries one result per volume: low/high bounds on each axis,
//   any_found and crop_needed. An empty volume reports the origin voxel.
//   The APB port holds threshold (0x0), size_x (0x4), size_y (0x8) and
//   size_z (0xC); write it only while no voxel is in flight. A size written
//   mid-volume keeps the position counters.
//   Throughput: one voxel per cycle, back to back, while the result register
//   can take a box. A result passes through the input register, then the
//   result register, before it shows on out_chan.
//   Reset clears the position counters and the box; registers return to
//   threshold 0 and 1024 voxels on each axis.
//   While a result waits on out_chan, voxels keep flowing; only the last
//   voxel of the next volume holds in the input register until the
//   waiting result is transferred, and in_chan.ready drops behind it.
// ----------------------------------------------------------------------------
module volume_threshold_bounding_box_core import vtbb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  vtbb_in_if.sink               in_chan,
  vtbb_out_if.source            out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  vtbb_cfg_t    cfg;
  vtbb_push_t   push;
  logic         res_ready;
  logic         in_ready;
  logic         out_valid;
  vtbb_result_t out_data;

  vtbb_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vtbb_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_chan.valid),
    .in_voxel  (in_chan.voxel_value),
    .in_ready  (in_ready),
    .res_ready (res_ready),
    .push      (push)
  );

  vtbb_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .out_data  (out_data)
  );

  assign in_chan.ready        = in_ready;
  assign out_chan.valid       = out_valid;
  assign out_chan.low_x       = out_data.low_x;
  assign out_chan.high_x      = out_data.high_x;
  assign out_chan.low_y       = out_data.low_y;
  assign out_chan.high_y      = out_data.high_y;
  assign out_chan.low_z       = out_data.low_z;
  assign out_chan.high_z      = out_data.high_z;
  assign out_chan.any_found   = out_data.any_found;
  assign out_chan.crop_needed = out_data.crop_needed;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams voxel volumes into the bounding box core and checks every box
// result against a cycle-free model of the scan kept inside the bench.
// Registers are written over APB between volumes and once part way through
// a volume, and both channel sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import vtbb_pkg::*;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 150;
  localparam int PHASE_VOLUMES = 6;

  typedef enum int {FILL_DENSITY, FILL_BLOCK, FILL_CORNERS} fill_mode_t;

  // One directed volume: settings, background, one marked voxel, optional
  // size_z rewrite part way through, optional expected box
  typedef struct {
    logic [VAL_W-1:0]  threshold;
    logic [SIZE_W-1:0] size_x;
    logic [SIZE_W-1:0] size_y;
    logic [SIZE_W-1:0] size_z;
    logic [VAL_W-1:0]  fill;
    logic [VAL_W-1:0]  spot;
    int                spot_x;
    int                spot_y;
    int                spot_z;
    int                split_after;
    logic [SIZE_W-1:0] split_size_z;
    bit                typed;
    vtbb_result_t      box;
  } scan_case_t;

  scan_case_t directed_cases [9] = '{
    '{16'h0000, 11'd1, 11'd1, 11'd1, 16'h0000, 16'h0000, 0, 0, 0, 0, 11'd0, 1'b1,
      '{10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0}},
    '{16'h0000, 11'd1, 11'd1, 11'd1, 16'h0000, 16'hFFFF, 0, 0, 0, 0, 11'd0, 1'b1,
      '{10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b1, 1'b0}},
    '{16'hFFFF, 11'd1, 11'd1, 11'd1, 16'h0000, 16'hFFFF, 0, 0, 0, 0, 11'd0, 1'b1,
      '{10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0}},
    '{16'hFFFE, 11'd1, 11'd1, 11'd1, 16'h0000, 16'hFFFF, 0, 0, 0, 0, 11'd0, 1'b1,
      '{10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b1, 1'b0}},
    // empty volume bigger than one voxel: origin box, crop set
    '{16'd100, 11'd2, 11'd1, 11'd2, 16'h0000, 16'h0000, 0, 0, 0, 0, 11'd0, 1'b1,
      '{10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b1}},
    '{16'd100, 11'd2, 11'd2, 11'd1, 16'd101, 16'd101, 0, 0, 0, 0, 11'd0, 1'b1,
      '{10'd0, 10'd1, 10'd0, 10'd1, 10'd0, 10'd0, 1'b1, 1'b0}},
    // zero sizes count as one
    '{16'd5, 11'd0, 11'd1, 11'd0, 16'h0000, 16'd6, 0, 0, 0, 0, 11'd0, 1'b1,
      '{10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b1, 1'b0}},
    '{16'h7FFF, 11'd2, 11'd1, 11'd3, 16'h7FFF, 16'h8000, 1, 0, 2, 0, 11'd0, 1'b1,
      '{10'd1, 10'd1, 10'd0, 10'd0, 10'd2, 10'd2, 1'b1, 1'b1}},
    // shrink size_z below the z counter mid-volume
    '{16'h0000, 11'd1, 11'd2, 11'd4, 16'd1, 16'd1, 0, 0, 0, 3, 11'd2, 1'b0,
      '{10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0}}
  };

  int idle_plan  [4] = '{0, 52, 0, 32};
  int stall_plan [4] = '{0, 0, 52, 32};

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  vtbb_in_if  voxel_if ();
  vtbb_out_if box_if ();

  volume_threshold_bounding_box_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (voxel_if),
    .out_chan (box_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Scan model: register copy, position counters and running box
  vtbb_cfg_t        cfg_mirror;
  logic [POS_W-1:0] scan_x, scan_y, scan_z;
  logic [POS_W-1:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
  logic             hit_seen;
  bit               volume_done;
  bit               typed_next;
  vtbb_result_t     typed_box;
  vtbb_result_t     box_q [$];

  int items_sent;
  int volumes_done;
  int errors;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_ticket;
  int hold_seen;
  int hold_left;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int clamp_extent(input logic [SIZE_W-1:0] s);
    if (s == '0) begin
      return 1;
    end
    if (int'(s) > MAX_DIM) begin
      return MAX_DIM;
    end
    return int'(s);
  endfunction

  function automatic logic [VAL_W-1:0] over_level(input logic [VAL_W-1:0] level);
    if (level == '1) begin
      return '1;
    end
    return VAL_W'($urandom_range(65535, int'(level) + 1));
  endfunction

  function automatic logic [VAL_W-1:0] under_level(input logic [VAL_W-1:0] level);
    return VAL_W'($urandom_range(int'(level), 0));
  endfunction

  function automatic logic [SIZE_W-1:0] rand_extent();
    case ($urandom_range(19))
      0: begin
        return '0;
      end
      1, 2: begin
        return SIZE_W'($urandom_range(12, 5));
      end
      default: begin
        return SIZE_W'($urandom_range(4, 1));
      end
    endcase
  endfunction

  task automatic clear_box();
    scan_x   = '0;
    scan_y   = '0;
    scan_z   = '0;
    lo_x     = '1;
    lo_y     = '1;
    lo_z     = '1;
    hi_x     = '0;
    hi_y     = '0;
    hi_z     = '0;
    hit_seen = 1'b0;
  endtask

  // Fold one accepted voxel into the box; queue the box at the volume's end
  task automatic track_voxel(input logic [VAL_W-1:0] v);
    int               ex, ey, ez;
    logic [VAL_W-1:0] sample;
    vtbb_result_t     box;
    ex = clamp_extent(cfg_mirror.size_x);
    ey = clamp_extent(cfg_mirror.size_y);
    ez = clamp_extent(cfg_mirror.size_z);
    sample = v & VOXEL_MASK;
    volume_done = 1'b0;
    items_sent++;
    if (sample > cfg_mirror.threshold) begin
      if (scan_x < lo_x) lo_x = scan_x;
      if (scan_x > hi_x) hi_x = scan_x;
      if (scan_y < lo_y) lo_y = scan_y;
      if (scan_y > hi_y) hi_y = scan_y;
      if (scan_z < lo_z) lo_z = scan_z;
      if (scan_z > hi_z) hi_z = scan_z;
      hit_seen = 1'b1;
    end
    // a counter at or past its extent minus one wraps
    if (int'(scan_z) + 1 < ez) begin
      scan_z++;
      return;
    end
    scan_z = '0;
    if (int'(scan_y) + 1 < ey) begin
      scan_y++;
      return;
    end
    scan_y = '0;
    if (int'(scan_x) + 1 < ex) begin
      scan_x++;
      return;
    end
    box = '0;
    box.any_found = hit_seen;
    if (hit_seen) begin
      box.low_x  = lo_x;
      box.high_x = hi_x;
      box.low_y  = lo_y;
      box.high_y = hi_y;
      box.low_z  = lo_z;
      box.high_z = hi_z;
    end
    box.crop_needed = (int'(box.high_x) - int'(box.low_x) + 1 != ex) ||
                      (int'(box.high_y) - int'(box.low_y) + 1 != ey) ||
                      (int'(box.high_z) - int'(box.low_z) + 1 != ez);
    if (typed_next) begin
      box_q.push_back(typed_box);
      typed_next = 1'b0;
    end else begin
      box_q.push_back(box);
    end
    clear_box();
    volume_done = 1'b1;
    volumes_done++;
  endtask

  // Offer one voxel, with random idle cycles ahead of it, until transfer
  task automatic push_voxel(input logic [VAL_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      voxel_if.valid <= 1'b0;
      @(posedge clk);
    end
    voxel_if.valid       <= 1'b1;
    voxel_if.voxel_value <= v;
    do @(posedge clk); while (!voxel_if.ready);
    track_voxel(v);
  endtask

  // Drop valid and hold until every queued box has arrived and the core is quiet
  task automatic settle();
    voxel_if.valid <= 1'b0;
    while (box_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup phase, access phase until pready, then idle before the next transfer
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_THRESHOLD: begin
        cfg_mirror.threshold = value[VAL_W-1:0];
      end
      REG_SIZE_X: begin
        cfg_mirror.size_x = value[SIZE_W-1:0];
      end
      REG_SIZE_Y: begin
        cfg_mirror.size_y = value[SIZE_W-1:0];
      end
      REG_SIZE_Z: begin
        cfg_mirror.size_z = value[SIZE_W-1:0];
      end
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  task automatic write_config(input logic [VAL_W-1:0] thr, input logic [SIZE_W-1:0] sx,
                              input logic [SIZE_W-1:0] sy, input logic [SIZE_W-1:0] sz);
    write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(REG_SIZE_X, CFG_DATA_W'(sx));
    write_reg(REG_SIZE_Y, CFG_DATA_W'(sy));
    write_reg(REG_SIZE_Z, CFG_DATA_W'(sz));
  endtask

  task automatic random_config();
    logic [VAL_W-1:0] thr;
    case ($urandom_range(5))
      0: begin
        thr = '0;
      end
      1: begin
        thr = '1;
      end
      default: begin
        thr = VAL_W'($urandom_range(65535));
      end
    endcase
    write_config(thr, rand_extent(), rand_extent(), rand_extent());
  endtask

  task automatic run_directed();
    scan_case_t c;
    int         sent;
    foreach (directed_cases[i]) begin
      c = directed_cases[i];
      settle();
      write_config(c.threshold, c.size_x, c.size_y, c.size_z);
      typed_next = c.typed;
      typed_box  = c.box;
      sent = 0;
      do begin
        if (c.split_after != 0 && sent == c.split_after) begin
          settle();
          write_reg(REG_SIZE_Z, CFG_DATA_W'(c.split_size_z));
        end
        if (scan_x == c.spot_x && scan_y == c.spot_y && scan_z == c.spot_z) begin
          push_voxel(c.spot);
        end else begin
          push_voxel(c.fill);
        end
        sent++;
      end while (!volume_done);
    end
  endtask

  // One whole volume with random content shaped by the fill mode
  task automatic run_volume(input fill_mode_t mode);
    int  ex, ey, ez;
    int  density;
    int  bx0, bx1, by0, by1, bz0, bz1;
    bit  lit;
    ex = clamp_extent(cfg_mirror.size_x);
    ey = clamp_extent(cfg_mirror.size_y);
    ez = clamp_extent(cfg_mirror.size_z);
    case ($urandom_range(4))
      0: density = 0;
      1: density = 2;
      2: density = 20;
      3: density = 60;
      default: density = 100;
    endcase
    bx0 = $urandom_range(ex - 1, 0);
    bx1 = $urandom_range(ex - 1, bx0);
    by0 = $urandom_range(ey - 1, 0);
    by1 = $urandom_range(ey - 1, by0);
    bz0 = $urandom_range(ez - 1, 0);
    bz1 = $urandom_range(ez - 1, bz0);
    do begin
      case (mode)
        FILL_BLOCK: begin
          lit = scan_x >= bx0 && scan_x <= bx1 && scan_y >= by0 && scan_y <= by1 &&
                scan_z >= bz0 && scan_z <= bz1 && $urandom_range(9) < 8;
        end
        FILL_CORNERS: begin
          lit = (scan_x == 0 || scan_x == ex - 1) && (scan_y == 0 || scan_y == ey - 1) &&
                (scan_z == 0 || scan_z == ez - 1);
        end
        default: begin
          lit = $urandom_range(99) < density;
        end
      endcase
      if (lit) begin
        push_voxel(over_level(cfg_mirror.threshold));
      end else begin
        push_voxel(under_level(cfg_mirror.threshold));
      end
    end while (!volume_done);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_box();
    vtbb_result_t want;
    if (box_q.size() == 0) begin
      $display("%0t: box result with no volume pending, expected none, actual %0d..%0d",
               $time, box_if.low_x, box_if.high_x);
      errors++;
      return;
    end
    want = box_q.pop_front();
    check_field("low_x", want.low_x, box_if.low_x);
    check_field("high_x", want.high_x, box_if.high_x);
    check_field("low_y", want.low_y, box_if.low_y);
    check_field("high_y", want.high_y, box_if.high_y);
    check_field("low_z", want.low_z, box_if.low_z);
    check_field("high_z", want.high_z, box_if.high_z);
    check_field("any_found", want.any_found, box_if.any_found);
    check_field("crop_needed", want.crop_needed, box_if.crop_needed);
  endtask

  // Result side: check each transfer, then stall at random or for a hold
  always @(posedge clk) begin
    if (!rst_n) begin
      box_if.ready <= 1'b0;
    end else begin
      if (box_if.valid && box_if.ready) begin
        check_box();
      end
      if (hold_ticket != hold_seen) begin
        hold_seen = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        box_if.ready <= 1'b0;
        hold_left--;
      end else begin
        box_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    int phase_items;
    int phase_volumes;
    rst_n                <= 1'b0;
    voxel_if.valid       <= 1'b0;
    voxel_if.voxel_value <= '0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    items_sent     = 0;
    volumes_done   = 0;
    errors         = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_ticket    = 0;
    hold_seen      = 0;
    hold_left      = 0;
    typed_next     = 1'b0;
    cfg_mirror     = '{threshold: '0, size_x: SIZE_RESET, size_y: SIZE_RESET,
                       size_z: SIZE_RESET};
    clear_box();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    for (int p = 0; p < 4; p++) begin
      settle();
      send_idle_pct  = idle_plan[p];
      recv_stall_pct = stall_plan[p];
      if (p == 0) begin
        // hold the result side while small volumes keep coming, so the core backs up
        write_config(VAL_W'($urandom_range(65535)), 11'd2, 11'd2, 11'd2);
        hold_ticket++;
        repeat (6) run_volume(fill_mode_t'($urandom_range(2)));
        settle();
      end
      random_config();
      phase_items   = items_sent;
      phase_volumes = volumes_done;
      while (items_sent - phase_items < PHASE_ITEMS ||
             volumes_done - phase_volumes < PHASE_VOLUMES) begin
        run_volume(fill_mode_t'($urandom_range(2)));
        if ($urandom_range(3) == 0) begin
          settle();
          random_config();
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/vtbb_pkg.sv
rtl/core/vtbb_if.sv
rtl/core/vtbb_cfg_regs.sv
rtl/core/vtbb_scan.sv
rtl/core/vtbb_out_reg.sv
rtl/core/volume_threshold_bounding_box_core.sv
sim/testbench.sv
